// ----- sv/two_beam_direction_people_counter_macros.svh -----
// Assertion helpers for the people counter.
`ifndef TWO_BEAM_DIRECTION_PEOPLE_COUNTER_MACROS_SVH
`define TWO_BEAM_DIRECTION_PEOPLE_COUNTER_MACROS_SVH

// same-cycle implication
`define TBDPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("people counter assertion failed");

// next-cycle implication
`define TBDPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("people counter assertion failed");

`endif

// ----- sv/tbdpc_pkg.sv -----
`default_nettype none

package tbdpc_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int CFG_DATA_WIDTH      = 16;
    localparam int CFG_INDEX_WIDTH     = 2;
    localparam int PERSON_COUNT_WIDTH  = 16;

    localparam logic [7:0]  QUIET_TICKS_RESET     = 8'd20;
    localparam logic [15:0] RELAY_ON_ABOVE_RESET  = 16'd1;
    localparam logic [15:0] RELAY_OFF_BELOW_RESET = 16'd1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUIET_TICKS     = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RELAY_ON_ABOVE  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RELAY_OFF_BELOW = 2'd2;

    typedef enum logic [1:0] {
        BEAM_NONE = 2'd0,
        BEAM_A    = 2'd1,
        BEAM_B    = 2'd2
    } beam_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

endpackage

`default_nettype wire

// ----- sv/two_beam_direction_people_counter.sv -----
// Two-beam doorway people counter.
// Input channel (in_valid/in_ready): one word per sampling tick, carrying
// beam_a_clear and beam_b_clear (1 = beam clear). A first break picks the
// leading beam, single-beam ticks track the trailing beam, and after
// quiet_ticks clear ticks past the first clear tick, the pass is scored.
// Output channel (out_valid/out_ready): one word per scored pass with
// person_count (low 16 bits), relay_active and pass_direction
// (0 none, 1 entry, 2 exit). Ticks that score nothing yield no word.
// Output timing: the result is registered and appears in the cycle after the scoring tick is taken.
// Throughput: one tick per cycle while in_ready is high; the tick is decoded by the phase
// logic and the output register is loaded in the same cycle.
// Stall: the output register holds its word while out_ready is low; a new
// tick is taken whenever that register is empty or being drained.
// Config: cfg_write_en with cfg_index/cfg_data writes a register at once;
// index 0 quiet_ticks, 1 relay_on_above, 2 relay_off_below, 3 ignored.
// Reset: rst_n (async, low) returns to idle with zero count, relay off,
// and register values 20, 1, 1.
`default_nettype none
`include "two_beam_direction_people_counter_macros.svh"

module two_beam_direction_people_counter #(
    parameter int COUNT_WIDTH = tbdpc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic                                   beam_a_clear,
    input  wire logic                                   beam_b_clear,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [tbdpc_pkg::PERSON_COUNT_WIDTH-1:0]    person_count,
    output logic                                        relay_active,
    output logic [1:0]                                  pass_direction,
    input  wire logic                                   cfg_write_en,
    input  wire logic [tbdpc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [tbdpc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > tbdpc_pkg::PERSON_COUNT_WIDTH) ?
                               COUNT_WIDTH : tbdpc_pkg::PERSON_COUNT_WIDTH;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TRACK = 2'd1,
        PH_QUIET = 2'd2
    } phase_t;

    logic [7:0]  quiet_ticks_reg;
    logic [15:0] relay_on_above_reg;
    logic [15:0] relay_off_below_reg;

    phase_t                 phase_reg, phase_next;
    tbdpc_pkg::beam_t       first_beam_reg, first_beam_next;
    tbdpc_pkg::beam_t       last_beam_reg, last_beam_next;
    logic [7:0]             quiet_count_reg, quiet_count_next;
    logic [COUNT_WIDTH-1:0] occupants_reg, occupants_next;
    logic                   relay_reg, relay_next;
    tbdpc_pkg::dir_t        dir_next;
    logic                   score;

    logic                   out_valid_reg;
    logic [tbdpc_pkg::PERSON_COUNT_WIDTH-1:0] person_count_reg;
    logic                   relay_active_reg;
    tbdpc_pkg::dir_t        pass_direction_reg;

    logic                   in_fire;
    logic [7:0]             quiet_inc;
    logic [CMP_WIDTH-1:0]   occ_ext;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign quiet_inc = quiet_count_reg + 8'd1;
    assign occ_ext  = CMP_WIDTH'(occupants_next);

    always_comb
    begin
        phase_next       = phase_reg;
        first_beam_next  = first_beam_reg;
        last_beam_next   = last_beam_reg;
        quiet_count_next = quiet_count_reg;
        occupants_next   = occupants_reg;
        dir_next         = tbdpc_pkg::DIR_NONE;
        score            = 1'b0;
        case (phase_reg)
            PH_TRACK:
            begin
                if (beam_a_clear && !beam_b_clear)
                begin
                    last_beam_next = tbdpc_pkg::BEAM_B;
                end
                if (!beam_a_clear && beam_b_clear)
                begin
                    last_beam_next = tbdpc_pkg::BEAM_A;
                end
                if (beam_a_clear && beam_b_clear)
                begin
                    phase_next       = PH_QUIET;
                    quiet_count_next = 8'd0;
                end
            end
            PH_QUIET:
            begin
                if (!beam_a_clear || !beam_b_clear)
                begin
                    phase_next = PH_TRACK;
                end
                else
                begin
                    quiet_count_next = quiet_inc;
                    if (quiet_inc == quiet_ticks_reg)
                    begin
                        score = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (!beam_a_clear)
                begin
                    first_beam_next = tbdpc_pkg::BEAM_A;
                end
                if (!beam_b_clear)
                begin
                    first_beam_next = tbdpc_pkg::BEAM_B;
                end
                if (!beam_a_clear || !beam_b_clear)
                begin
                    phase_next = PH_TRACK;
                end
            end
        endcase

        if (score)
        begin
            if (first_beam_reg == tbdpc_pkg::BEAM_A && last_beam_next == tbdpc_pkg::BEAM_B)
            begin
                if (occupants_reg != {COUNT_WIDTH{1'b1}})
                begin
                    occupants_next = COUNT_WIDTH'(occupants_reg + 1'b1);
                    dir_next       = tbdpc_pkg::DIR_UP;
                end
            end
            else if (first_beam_reg == tbdpc_pkg::BEAM_B &&
                     last_beam_next == tbdpc_pkg::BEAM_A)
            begin
                if (occupants_reg != '0)
                begin
                    occupants_next = COUNT_WIDTH'(occupants_reg - 1'b1);
                    dir_next       = tbdpc_pkg::DIR_DOWN;
                end
            end
            phase_next       = PH_IDLE;
            first_beam_next  = tbdpc_pkg::BEAM_NONE;
            last_beam_next   = tbdpc_pkg::BEAM_NONE;
            quiet_count_next = 8'd0;
        end
    end

    // relay hysteresis, off wins
    always_comb
    begin
        relay_next = relay_reg;
        if (occ_ext > CMP_WIDTH'(relay_on_above_reg))
        begin
            relay_next = 1'b1;
        end
        if (occ_ext < CMP_WIDTH'(relay_off_below_reg))
        begin
            relay_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_ticks_reg     <= tbdpc_pkg::QUIET_TICKS_RESET;
            relay_on_above_reg  <= tbdpc_pkg::RELAY_ON_ABOVE_RESET;
            relay_off_below_reg <= tbdpc_pkg::RELAY_OFF_BELOW_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                tbdpc_pkg::REG_QUIET_TICKS:     quiet_ticks_reg     <= cfg_data[7:0];
                tbdpc_pkg::REG_RELAY_ON_ABOVE:  relay_on_above_reg  <= cfg_data;
                tbdpc_pkg::REG_RELAY_OFF_BELOW: relay_off_below_reg <= cfg_data;
                default:;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            first_beam_reg     <= tbdpc_pkg::BEAM_NONE;
            last_beam_reg      <= tbdpc_pkg::BEAM_NONE;
            quiet_count_reg    <= 8'd0;
            occupants_reg      <= '0;
            relay_reg          <= 1'b0;
            out_valid_reg      <= 1'b0;
            person_count_reg   <= '0;
            relay_active_reg   <= 1'b0;
            pass_direction_reg <= tbdpc_pkg::DIR_NONE;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg       <= phase_next;
                first_beam_reg  <= first_beam_next;
                last_beam_reg   <= last_beam_next;
                quiet_count_reg <= quiet_count_next;
                if (score)
                begin
                    occupants_reg <= occupants_next;
                    relay_reg     <= relay_next;
                end
            end
            if (in_fire && score)
            begin
                out_valid_reg      <= 1'b1;
                person_count_reg   <= occ_ext[tbdpc_pkg::PERSON_COUNT_WIDTH-1:0];
                relay_active_reg   <= relay_next;
                pass_direction_reg <= dir_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign person_count   = person_count_reg;
    assign relay_active   = relay_active_reg;
    assign pass_direction = pass_direction_reg;

    `TBDPC_ASSERT_NEXT(a_score_gives_word, clk, rst_n, in_fire && score, out_valid)
    `TBDPC_ASSERT_NEXT(a_score_returns_idle, clk, rst_n, in_fire && score, phase_reg == PH_IDLE)
    `TBDPC_ASSERT_IMPLY(a_entry_nonzero, clk, rst_n, out_valid && pass_direction == tbdpc_pkg::DIR_UP, occupants_reg != '0)
    `TBDPC_ASSERT_IMPLY(a_dir_code, clk, rst_n, out_valid, pass_direction <= tbdpc_pkg::DIR_DOWN)

endmodule

`default_nettype wire
